FILE: design/acl_credit_flow_control_core_macros.svh
// Assertion macros for the ACL credit flow control core.
// Included by the top level; empty bodies under SYNTHESIS.
`ifndef ACL_CREDIT_FLOW_CONTROL_CORE_MACROS_SVH
`define ACL_CREDIT_FLOW_CONTROL_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define ACF_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define ACF_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define ACF_ASSERT_IMP(label, clk, rst_n, a, c, msg)
`define ACF_ASSERT_NXT(label, clk, rst_n, a, c, msg)
`endif
`endif

FILE: design/acf_pkg.sv
// Shared types and constants for the ACL credit flow control core.
// No dependencies.
`default_nettype none
package acf_pkg;
    localparam int QUEUE_DEPTH = 16;
    localparam int PENDING_ENTRIES = 16;
    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int PW = $clog2(PENDING_ENTRIES);

    localparam logic [1:0] CMD_ENQ = 2'd0;
    localparam logic [1:0] CMD_DONE = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_TOO_LONG = 3'd1;
    localparam logic [2:0] ST_FULL = 3'd2;
    localparam logic [2:0] ST_DISABLED = 3'd3;
    localparam logic [2:0] ST_UNKNOWN = 3'd4;
    localparam logic [2:0] ST_MISMATCH = 3'd5;
    localparam logic [2:0] ST_NONE = 3'd6;

    localparam logic [2:0] REG_ENABLE = 3'd0;
    localparam logic [2:0] REG_BR_LEN = 3'd1;
    localparam logic [2:0] REG_BR_PKTS = 3'd2;
    localparam logic [2:0] REG_LE_LEN = 3'd3;
    localparam logic [2:0] REG_LE_PKTS = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE, S_SRCH, S_APPLY, S_STATUS, S_QRD, S_QCHK, S_PSRCH, S_PDEC, S_REL, S_DONE
    } state_t;

    // pending table search request and answer
    typedef struct packed {
        logic        start;
        logic [11:0] handle;
    } srch_req_t;

    typedef struct packed {
        logic          busy;
        logic          hit;
        logic [PW-1:0] hit_idx;
        logic          free_ok;
        logic [PW-1:0] free_idx;
    } srch_rsp_t;
endpackage
`default_nettype wire

FILE: design/acl_credit_flow_control_core.sv
// Credit gate for HCI ACL transmit. Each request answers with one status result, then one
// result per released packet, and tlast marks the final result of the request. A request
// holds the input from acceptance until ready again; when the queue is empty or the block
// is disabled, it runs the pending table search, then applies the command, loads the
// status, presents the final result and returns to idle. A queued packet whose pool has
// credit takes longer than one whose pool has none, since the shared search unit walks the
// pending table once more for its handle. Cycles with m_tready low add to this. Each
// result is held one step so that tlast lands on the true final one.
// Depends on acf_pkg, acf_search and the macros header.
`default_nettype none
`include "acl_credit_flow_control_core_macros.svh"
module acl_credit_flow_control_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // cmd[1:0] packet_tag[9:2] conn_handle[21:10] link_kind[22] payload_len[38:23]
    // done_count[54:39], zero fill to 56
    input  wire logic [55:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // result_kind[0] status_code[3:1] out_tag[11:4] out_handle[23:12] out_link_kind[24]
    output logic [31:0]      m_tdata,
    output logic             m_tlast
);
    localparam int PE = acf_pkg::PENDING_ENTRIES;
    localparam int QD = acf_pkg::QUEUE_DEPTH;
    localparam int QW = acf_pkg::QW;

    logic        en_reg;
    logic [15:0] brlen_reg, brpk_reg, lelen_reg, lepk_reg;
    logic [15:0] brif_reg, leif_reg, fb_reg, fl_reg;

    logic [20:0]   q_mem [QD];
    logic [20:0]   qrd_reg;
    logic [QW:0]   fill_reg, ri_reg, wi_reg;

    logic [PE-1:0] pv_reg;
    logic [11:0]   ph_reg [PE];
    logic          pk_reg [PE];
    logic [15:0]   pc_reg [PE];

    acf_pkg::state_t st_reg, st_next;
    logic [55:0] in_reg;
    logic [2:0]  status_next;
    logic [24:0] hold_reg;
    logic        rel_kind_reg;

    acf_pkg::srch_req_t sreq;
    acf_pkg::srch_rsp_t srsp;

    acf_search u_srch (.clk, .rst_n, .req(sreq), .valid(pv_reg), .handles(ph_reg), .rsp(srsp));

    logic [1:0]  i_cmd;
    logic [7:0]  i_tag;
    logic [11:0] i_h;
    logic        i_kind;
    logic [15:0] i_len, i_done;
    logic        le_av;
    logic [15:0] mtu;
    logic        enq_ok;
    assign i_cmd = in_reg[1:0];
    assign i_tag = in_reg[9:2];
    assign i_h = in_reg[21:10];
    assign i_kind = in_reg[22];
    assign i_len = in_reg[38:23];
    assign i_done = in_reg[54:39];
    assign le_av = (lelen_reg != 16'd0) && (lepk_reg != 16'd0);
    assign mtu = (i_kind && le_av) ? lelen_reg : brlen_reg;
    assign enq_ok = en_reg && (i_len <= mtu) && (fill_reg < (QW+1)'(QD));

    logic use_le, scan_more, rel_ok;
    assign use_le = qrd_reg[20] && le_av;
    assign scan_more = en_reg && (ri_reg < fill_reg);
    assign rel_ok = srsp.hit ? (pc_reg[srsp.hit_idx] != 16'hFFFF) : srsp.free_ok;

    // next state
    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            acf_pkg::S_IDLE:   if (s_tvalid) st_next = acf_pkg::S_SRCH;
            acf_pkg::S_SRCH:   if (!srsp.busy) st_next = acf_pkg::S_APPLY;
            acf_pkg::S_APPLY:  st_next = acf_pkg::S_STATUS;
            acf_pkg::S_STATUS: st_next = scan_more ? acf_pkg::S_QRD : acf_pkg::S_DONE;
            acf_pkg::S_QRD:    st_next = acf_pkg::S_QCHK;
            acf_pkg::S_QCHK:
                if ((use_le ? fl_reg : fb_reg) != 16'd0) st_next = acf_pkg::S_PSRCH;
                else st_next = acf_pkg::S_PDEC;
            acf_pkg::S_PSRCH:  if (!srsp.busy) st_next = acf_pkg::S_PDEC;
            acf_pkg::S_PDEC:   st_next = acf_pkg::S_REL;
            acf_pkg::S_REL:
                if (!rel_kind_reg || m_tready)
                    st_next = scan_more ? acf_pkg::S_QRD : acf_pkg::S_DONE;
            acf_pkg::S_DONE:   if (m_tready) st_next = acf_pkg::S_IDLE;
            default:           st_next = acf_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        s_tready = (st_reg == acf_pkg::S_IDLE);
        sreq.start = 1'b0;
        sreq.handle = i_h;
        m_tvalid = 1'b0;
        m_tdata = '0;
        m_tlast = 1'b0;
        unique case (st_reg)
            acf_pkg::S_IDLE:
            begin
                // in_reg loads at the accepting edge, so search on the live handle
                sreq.start = s_tvalid;
                sreq.handle = s_tdata[21:10];
            end
            acf_pkg::S_QCHK:
            begin
                sreq.start = (use_le ? fl_reg : fb_reg) != 16'd0;
                sreq.handle = qrd_reg[19:8];
            end
            acf_pkg::S_REL:
            begin
                // a new release pushes out the held result
                m_tvalid = rel_kind_reg;
                m_tdata = {7'd0, hold_reg};
            end
            acf_pkg::S_DONE:
            begin
                m_tvalid = 1'b1;
                m_tdata = {7'd0, hold_reg};
                m_tlast = 1'b1;
            end
            default: ;
        endcase
    end

    logic [15:0] pcnt;
    logic [15:0] credit;
    logic        hk;
    assign pcnt = pc_reg[srsp.hit_idx];
    assign hk = pk_reg[srsp.hit_idx];
    assign credit = (st_reg == acf_pkg::S_APPLY && i_cmd == acf_pkg::CMD_CLEAR) ? pcnt :
                    ((pcnt < i_done) ? pcnt : i_done);

    always_comb
    begin
        status_next = acf_pkg::ST_OK;
        unique case (i_cmd)
            acf_pkg::CMD_ENQ:
                if (!en_reg) status_next = acf_pkg::ST_DISABLED;
                else if (i_len > mtu) status_next = acf_pkg::ST_TOO_LONG;
                else if (fill_reg >= (QW+1)'(QD)) status_next = acf_pkg::ST_FULL;
            acf_pkg::CMD_DONE:
                if (!srsp.hit) status_next = acf_pkg::ST_UNKNOWN;
                else if (pcnt < i_done) status_next = acf_pkg::ST_MISMATCH;
            acf_pkg::CMD_CLEAR:
                if (!srsp.hit) status_next = acf_pkg::ST_NONE;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= acf_pkg::S_IDLE;
            en_reg <= 1'b0;
            brlen_reg <= '0;
            brpk_reg <= '0;
            lelen_reg <= '0;
            lepk_reg <= '0;
            brif_reg <= '0;
            leif_reg <= '0;
            fill_reg <= '0;
            pv_reg <= '0;
            ri_reg <= '0;
            wi_reg <= '0;
            rel_kind_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    acf_pkg::REG_ENABLE:  en_reg <= cfg_data[0];
                    acf_pkg::REG_BR_LEN:  brlen_reg <= cfg_data;
                    acf_pkg::REG_BR_PKTS: brpk_reg <= cfg_data;
                    acf_pkg::REG_LE_LEN:  lelen_reg <= cfg_data;
                    acf_pkg::REG_LE_PKTS: lepk_reg <= cfg_data;
                    default: ;
                endcase
            end
            unique case (st_reg)
                acf_pkg::S_APPLY:
                begin
                    if (i_cmd == acf_pkg::CMD_ENQ && enq_ok)
                        fill_reg <= fill_reg + 1'b1;
                    if ((i_cmd == acf_pkg::CMD_DONE || i_cmd == acf_pkg::CMD_CLEAR) && srsp.hit)
                    begin
                        if (hk && le_av)
                            leif_reg <= (leif_reg > credit) ? leif_reg - credit : 16'd0;
                        else
                            brif_reg <= (brif_reg > credit) ? brif_reg - credit : 16'd0;
                        if (i_cmd == acf_pkg::CMD_CLEAR || pcnt == credit)
                            pv_reg[srsp.hit_idx] <= 1'b0;
                    end
                    ri_reg <= '0;
                    wi_reg <= '0;
                end
                acf_pkg::S_QRD: ri_reg <= ri_reg + 1'b1;
                acf_pkg::S_QCHK: rel_kind_reg <= 1'b0;
                acf_pkg::S_PDEC:
                begin
                    if (srsp.free_ok || srsp.hit)
                        if (rel_ok && ((use_le ? fl_reg : fb_reg) != 16'd0))
                        begin
                            rel_kind_reg <= 1'b1;
                            if (!srsp.hit) pv_reg[srsp.free_idx] <= 1'b1;
                            if (use_le) leif_reg <= leif_reg + 1'b1;
                            else brif_reg <= brif_reg + 1'b1;
                        end
                end
                acf_pkg::S_REL:
                begin
                    if (!rel_kind_reg) wi_reg <= wi_reg + 1'b1;
                    if (st_next != acf_pkg::S_REL && !scan_more) fill_reg <= rel_kind_reg ?
                        wi_reg : wi_reg + 1'b1;
                end
                acf_pkg::S_STATUS:
                    if (en_reg && !scan_more) fill_reg <= '0;
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (st_reg == acf_pkg::S_IDLE && s_tvalid) in_reg <= s_tdata;
        if (st_reg == acf_pkg::S_APPLY)
        begin
            hold_reg <= {21'd0, status_next, 1'b0};
            unique case (i_cmd)
                acf_pkg::CMD_ENQ:
                    if (enq_ok) q_mem[fill_reg[QW-1:0]] <= {i_kind, i_h, i_tag};
                acf_pkg::CMD_DONE:
                    if (srsp.hit) pc_reg[srsp.hit_idx] <= pcnt - credit;
                acf_pkg::CMD_CLEAR:
                    if (srsp.hit) pc_reg[srsp.hit_idx] <= '0;
                default: ;
            endcase
        end
        if (st_reg == acf_pkg::S_STATUS)
        begin
            fb_reg <= (brpk_reg > brif_reg) ? brpk_reg - brif_reg : 16'd0;
            fl_reg <= (lepk_reg > leif_reg) ? lepk_reg - leif_reg : 16'd0;
        end
        if (st_reg == acf_pkg::S_QRD) qrd_reg <= q_mem[ri_reg[QW-1:0]];
        if (st_reg == acf_pkg::S_PDEC && rel_ok && (srsp.free_ok || srsp.hit) &&
            ((use_le ? fl_reg : fb_reg) != 16'd0))
        begin
            if (use_le) fl_reg <= fl_reg - 1'b1;
            else fb_reg <= fb_reg - 1'b1;
            if (srsp.hit) pc_reg[srsp.hit_idx] <= pcnt + 1'b1;
            else
            begin
                ph_reg[srsp.free_idx] <= qrd_reg[19:8];
                pk_reg[srsp.free_idx] <= qrd_reg[20];
                pc_reg[srsp.free_idx] <= 16'd1;
            end
        end
        // hold the new release until the next result or the end of the scan
        if (st_reg == acf_pkg::S_REL && rel_kind_reg && m_tready)
            hold_reg <= {qrd_reg[20], qrd_reg[19:8], qrd_reg[7:0], 3'd0, 1'b1};
        // compact: keep an unsent packet at the write slot
        if (st_reg == acf_pkg::S_REL && !rel_kind_reg) q_mem[wi_reg[QW-1:0]] <= qrd_reg;
    end

    `ACF_ASSERT_IMP(a_fill_max, clk, rst_n, 1'b1, fill_reg <= (QW+1)'(QD), "queue overfilled")
    `ACF_ASSERT_NXT(a_accept_busy, clk, rst_n, s_tvalid && s_tready, !s_tready, "ready after accept")
    `ACF_ASSERT_IMP(a_wr_le_rd, clk, rst_n, st_reg == acf_pkg::S_REL, wi_reg < ri_reg, "compact order")
endmodule
`default_nettype wire

FILE: design/acf_search.sv
// Sequential search of pending table valid/handle, one entry per cycle.
// Depends on acf_pkg.
`default_nettype none
module acf_search (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  acf_pkg::srch_req_t       req,
    input  wire logic [acf_pkg::PENDING_ENTRIES-1:0] valid,
    input  wire logic [11:0]         handles [acf_pkg::PENDING_ENTRIES],
    output acf_pkg::srch_rsp_t       rsp
);
    logic [acf_pkg::PW:0]   idx_reg, idx_next;
    logic                   busy_reg, busy_next;
    logic                   hit_reg, hit_next;
    logic [acf_pkg::PW-1:0] hidx_reg, hidx_next;
    logic                   fok_reg, fok_next;
    logic [acf_pkg::PW-1:0] fidx_reg, fidx_next;
    logic [11:0]            h_reg, h_next;
    logic [acf_pkg::PW-1:0] cur;

    assign cur = idx_reg[acf_pkg::PW-1:0];

    always_comb
    begin
        idx_next = idx_reg;
        busy_next = busy_reg;
        hit_next = hit_reg;
        hidx_next = hidx_reg;
        fok_next = fok_reg;
        fidx_next = fidx_reg;
        h_next = h_reg;
        if (req.start)
        begin
            idx_next = '0;
            busy_next = 1'b1;
            hit_next = 1'b0;
            fok_next = 1'b0;
            h_next = req.handle;
        end
        else if (busy_reg)
        begin
            if (valid[cur] && handles[cur] == h_reg && !hit_reg)
            begin
                hit_next = 1'b1;
                hidx_next = cur;
            end
            if (!valid[cur] && !fok_reg)
            begin
                fok_next = 1'b1;
                fidx_next = cur;
            end
            idx_next = idx_reg + 1'b1;
            if (idx_reg == (acf_pkg::PW+1)'(acf_pkg::PENDING_ENTRIES - 1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg <= '0;
            hit_reg <= 1'b0;
            fok_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg <= idx_next;
            hit_reg <= hit_next;
            fok_reg <= fok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hidx_reg <= hidx_next;
        fidx_reg <= fidx_next;
        h_reg <= h_next;
    end

    assign rsp.busy = busy_reg | req.start;
    assign rsp.hit = hit_reg;
    assign rsp.hit_idx = hidx_reg;
    assign rsp.free_ok = fok_reg;
    assign rsp.free_idx = fidx_reg;
endmodule
`default_nettype wire

FILE: bench/tb_acl_credit_flow_control_core.sv
`timescale 1ns / 100ps
// Self-checking bench for acl_credit_flow_control_core: random and directed requests,
// predicted credit/queue behavior, field-by-field result compare. Depends on acf_pkg and the DUT.
`default_nettype none
module tb_acl_credit_flow_control_core;

    localparam logic [1:0] CMD_NOP = 2'd3;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct {
        logic [1:0]  cmd;
        logic [7:0]  tag;
        logic [11:0] handle;
        logic        kind;
        logic [15:0] len;
        logic [15:0] done;
    } request_t;

    typedef struct {
        logic        rkind;
        logic [2:0]  status;
        logic [7:0]  tag;
        logic [11:0] handle;
        logic        lkind;
        logic        last;
    } result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tlast;

    acl_credit_flow_control_core u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    // predictor copy of registers and state
    logic        m_enable;
    logic [15:0] m_br_len, m_br_pkts, m_le_len, m_le_pkts;
    logic [7:0]  wq_tag [acf_pkg::QUEUE_DEPTH];
    logic [11:0] wq_handle [acf_pkg::QUEUE_DEPTH];
    logic        wq_kind [acf_pkg::QUEUE_DEPTH];
    int          wq_fill;
    logic        pt_valid [acf_pkg::PENDING_ENTRIES];
    logic [11:0] pt_handle [acf_pkg::PENDING_ENTRIES];
    logic        pt_kind [acf_pkg::PENDING_ENTRIES];
    logic [15:0] pt_count [acf_pkg::PENDING_ENTRIES];
    int          br_in_flight, le_in_flight;

    request_t request_q[$];
    result_t  expected_q[$];
    request_t cur_req;
    logic     req_taken;
    int       src_gap, snk_gap, holdoff_cnt;
    logic     no_idle;
    int       errors, n_requests, n_results, n_released, quiet_cycles;

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic bit le_pool();
        return m_le_len != 0 && m_le_pkts != 0;
    endfunction

    function automatic int find_pending(logic [11:0] h);
        for (int i = 0; i < acf_pkg::PENDING_ENTRIES; i++)
            if (pt_valid[i] && pt_handle[i] == h)
                return i;
        return -1;
    endfunction

    // return credits, saturating at zero
    function automatic void return_credits(logic kind, int n);
        if (kind && le_pool())
            le_in_flight = (le_in_flight > n) ? le_in_flight - n : 0;
        else
            br_in_flight = (br_in_flight > n) ? br_in_flight - n : 0;
    endfunction

    function automatic void push_result(logic rk, logic [2:0] st, logic [7:0] tag,
                                        logic [11:0] h, logic k);
        result_t r;
        r.rkind = rk;
        r.status = st;
        r.tag = tag;
        r.handle = h;
        r.lkind = k;
        r.last = 1'b0;
        expected_q.insert(expected_q.size(), r);
    endfunction

    function automatic void predict_request(request_t rq);
        logic [2:0]  st;
        logic [15:0] mtu;
        int          p, fb, fl, w, j;
        bit          shared, use_le, sent;
        st = acf_pkg::ST_OK;
        if (rq.cmd == acf_pkg::CMD_ENQ)
        begin
            mtu = (rq.kind && le_pool()) ? m_le_len : m_br_len;
            if (!m_enable)
                st = acf_pkg::ST_DISABLED;
            else if (rq.len > mtu)
                st = acf_pkg::ST_TOO_LONG;
            else if (wq_fill >= acf_pkg::QUEUE_DEPTH)
                st = acf_pkg::ST_FULL;
            else
            begin
                wq_tag[wq_fill] = rq.tag;
                wq_handle[wq_fill] = rq.handle;
                wq_kind[wq_fill] = rq.kind;
                wq_fill++;
            end
        end
        else if (rq.cmd == acf_pkg::CMD_DONE)
        begin
            p = find_pending(rq.handle);
            if (p < 0)
                st = acf_pkg::ST_UNKNOWN;
            else
            begin
                fb = rq.done;
                if (pt_count[p] < rq.done)
                begin
                    fb = pt_count[p];
                    st = acf_pkg::ST_MISMATCH;
                end
                pt_count[p] = 16'(pt_count[p] - fb);
                return_credits(pt_kind[p], fb);
                if (pt_count[p] == 0)
                    pt_valid[p] = 1'b0;
            end
        end
        else if (rq.cmd == acf_pkg::CMD_CLEAR)
        begin
            p = find_pending(rq.handle);
            if (p < 0)
                st = acf_pkg::ST_NONE;
            else
            begin
                return_credits(pt_kind[p], pt_count[p]);
                pt_valid[p] = 1'b0;
                pt_count[p] = 0;
            end
        end
        push_result(1'b0, st, 8'd0, 12'd0, 1'b0);

        if (m_enable)
        begin
            shared = !le_pool();
            fb = (m_br_pkts > br_in_flight) ? m_br_pkts - br_in_flight : 0;
            fl = (m_le_pkts > le_in_flight) ? m_le_pkts - le_in_flight : 0;
            w = 0;
            for (int i = 0; i < wq_fill; i++)
            begin
                use_le = wq_kind[i] && !shared;
                sent = 0;
                if ((use_le ? fl : fb) > 0)
                begin
                    p = find_pending(wq_handle[i]);
                    if (p >= 0)
                    begin
                        if (pt_count[p] != 16'hFFFF)
                        begin
                            pt_count[p]++;
                            sent = 1;
                        end
                    end
                    else
                    begin
                        for (j = 0; j < acf_pkg::PENDING_ENTRIES && !sent; j++)
                            if (!pt_valid[j])
                            begin
                                pt_valid[j] = 1'b1;
                                pt_handle[j] = wq_handle[i];
                                pt_kind[j] = wq_kind[i];
                                pt_count[j] = 16'd1;
                                sent = 1;
                            end
                    end
                end
                if (sent)
                begin
                    if (use_le)
                    begin
                        fl--;
                        le_in_flight++;
                    end
                    else
                    begin
                        fb--;
                        br_in_flight++;
                    end
                    push_result(1'b1, acf_pkg::ST_OK, wq_tag[i], wq_handle[i], wq_kind[i]);
                end
                else
                begin
                    wq_tag[w] = wq_tag[i];
                    wq_handle[w] = wq_handle[i];
                    wq_kind[w] = wq_kind[i];
                    w++;
                end
            end
            wq_fill = w;
        end
        expected_q[$].last = 1'b1;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        $display("mismatch on %s: got %0d expected %0d (result %0d)", what, got, want,
                 n_results);
    endtask

    // request driver
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            predict_request(cur_req);
            req_taken = 1'b1;
            n_requests++;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || req_taken))
        begin
            req_taken = 1'b0;
            if (src_gap > 0)
            begin
                src_gap--;
                s_tvalid <= 1'b0;
            end
            else if (request_q.size() > 0)
            begin
                cur_req = request_q[0];
                request_q.delete(0);
                s_tdata <= {1'b0, cur_req.done, cur_req.len, cur_req.kind,
                            cur_req.handle, cur_req.tag, cur_req.cmd};
                s_tvalid <= 1'b1;
                src_gap = rand_gap();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // result monitor
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (holdoff_cnt > 0)
            begin
                holdoff_cnt--;
                m_tready <= 1'b0;
            end
            else if (snk_gap > 0)
            begin
                snk_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                snk_gap = rand_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            n_results++;
            if (expected_q.size() == 0)
                report_mismatch("unexpected result data", m_tdata, 0);
            else
            begin
                result_t e;
                e = expected_q[0];
                expected_q.delete(0);
                if (m_tdata[0] !== e.rkind) report_mismatch("result_kind", m_tdata[0], e.rkind);
                if (m_tdata[3:1] !== e.status) report_mismatch("status", m_tdata[3:1], e.status);
                if (m_tdata[11:4] !== e.tag) report_mismatch("tag", m_tdata[11:4], e.tag);
                if (m_tdata[23:12] !== e.handle)
                    report_mismatch("handle", m_tdata[23:12], e.handle);
                if (m_tdata[24] !== e.lkind) report_mismatch("link_kind", m_tdata[24], e.lkind);
                if (m_tlast !== e.last) report_mismatch("last", m_tlast, e.last);
                if (e.rkind)
                    n_released++;
            end
        end
    end

    // watchdog: stop when nothing moves for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: %0d requests pending, %0d results outstanding",
                     request_q.size(), expected_q.size());
            $display("[acl_credit_flow_control_core] ERROR");
            $finish;
        end
    end

    task automatic wait_idle();
        while (request_q.size() > 0 || s_tvalid || expected_q.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        case (idx)
            acf_pkg::REG_ENABLE:  m_enable = val[0];
            acf_pkg::REG_BR_LEN:  m_br_len = val;
            acf_pkg::REG_BR_PKTS: m_br_pkts = val;
            acf_pkg::REG_LE_LEN:  m_le_len = val;
            acf_pkg::REG_LE_PKTS: m_le_pkts = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic configure(logic en, logic [15:0] bl, logic [15:0] bp,
                             logic [15:0] ll, logic [15:0] lp);
        wait_idle();
        write_reg(acf_pkg::REG_ENABLE, {15'd0, en});
        write_reg(acf_pkg::REG_BR_LEN, bl);
        write_reg(acf_pkg::REG_BR_PKTS, bp);
        write_reg(acf_pkg::REG_LE_LEN, ll);
        write_reg(acf_pkg::REG_LE_PKTS, lp);
    endtask

    task automatic add(logic [1:0] cmd, logic [7:0] tag, logic [11:0] h, logic k,
                       logic [15:0] len, logic [15:0] done);
        request_t rq;
        rq.cmd = cmd;
        rq.tag = tag;
        rq.handle = h;
        rq.kind = k;
        rq.len = len;
        rq.done = done;
        request_q.insert(request_q.size(), rq);
    endtask

    // random requests, mostly on a handle pool of the given size; lengths mostly 0 to 120
    task automatic add_random(int count, int handles);
        int r;
        logic [11:0] h;
        logic [15:0] len, done;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            h = ($urandom_range(0, 19) == 0) ? 12'($urandom) : 12'($urandom_range(0, handles - 1));
            len = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 120));
            done = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 3));
            if (r < 55)
                add(acf_pkg::CMD_ENQ, 8'($urandom), h, 1'($urandom), len, done);
            else if (r < 85)
                add(acf_pkg::CMD_DONE, 8'($urandom), h, 1'($urandom), len, done);
            else if (r < 96)
                add(acf_pkg::CMD_CLEAR, 8'($urandom), h, 1'($urandom), len, done);
            else
                add(CMD_NOP, 8'($urandom), h, 1'($urandom), len, done);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        req_taken = 1'b0;
        src_gap = 0;
        snk_gap = 0;
        holdoff_cnt = 0;
        no_idle = 1'b0;
        errors = 0;
        n_requests = 0;
        n_results = 0;
        n_released = 0;
        quiet_cycles = 0;
        m_enable = 0;
        m_br_len = 0;
        m_br_pkts = 0;
        m_le_len = 0;
        m_le_pkts = 0;
        wq_fill = 0;
        br_in_flight = 0;
        le_in_flight = 0;
        for (int i = 0; i < acf_pkg::PENDING_ENTRIES; i++)
        begin
            pt_valid[i] = 1'b0;
            pt_count[i] = '0;
        end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // disabled block: enqueue refused, reports and clears still answered
        add(acf_pkg::CMD_ENQ, 8'hFF, 12'hFFF, 1'b1, 16'hFFFF, 16'hFFFF);
        add(acf_pkg::CMD_DONE, 8'h00, 12'h000, 1'b0, 16'h0000, 16'h0001);
        add(acf_pkg::CMD_CLEAR, 8'h00, 12'h001, 1'b0, 16'h0000, 16'h0000);
        add(CMD_NOP, 8'hA5, 12'hABC, 1'b1, 16'h1234, 16'h5678);

        configure(1'b1, 16'd100, 16'd2, 16'd50, 16'd1);
        add(acf_pkg::CMD_ENQ, 8'h01, 12'd1, 1'b0, 16'd100, 16'd0);
        add(acf_pkg::CMD_ENQ, 8'h02, 12'd1, 1'b0, 16'd101, 16'd0);
        add(acf_pkg::CMD_ENQ, 8'h03, 12'd2, 1'b1, 16'd50, 16'd0);
        add(acf_pkg::CMD_ENQ, 8'h04, 12'd2, 1'b1, 16'd51, 16'd0);
        // credits spent: the rest waits and the queue overflows
        for (int i = 0; i < 18; i++)
            add(acf_pkg::CMD_ENQ, 8'(16 + i), 12'(i % 3), 1'(i % 2), 16'd0, 16'd0);
        add(acf_pkg::CMD_DONE, 8'h00, 12'd1, 1'b0, 16'd0, 16'd1);
        add(acf_pkg::CMD_DONE, 8'h00, 12'd2, 1'b0, 16'd0, 16'hFFFF);
        add(acf_pkg::CMD_CLEAR, 8'h00, 12'd1, 1'b0, 16'd0, 16'd0);
        add(acf_pkg::CMD_CLEAR, 8'h00, 12'd7, 1'b0, 16'd0, 16'd0);

        // long receiver stall while requests keep coming
        wait_idle();
        holdoff_cnt = 300;
        add_random(40, 4);

        // extremes, many handles so the pending table fills
        configure(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        no_idle = 1'b1;
        add_random(40, 32);
        wait_idle();
        no_idle = 1'b0;
        add_random(40, 32);

        // LE pool unavailable: one shared pool; then shrink credits below in-flight
        configure(1'b1, 16'd200, 16'd3, 16'd0, 16'd9);
        add_random(70, 5);
        configure(1'b1, 16'd80, 16'd1, 16'd60, 16'd1);
        add_random(70, 5);

        // disabled mid-run with packets pending
        configure(1'b0, 16'd80, 16'd4, 16'd60, 16'd2);
        add_random(30, 5);

        for (int k = 0; k < 4; k++)
        begin
            configure(1'b1, 16'($urandom_range(0, 150)), 16'($urandom_range(0, 6)),
                      16'($urandom_range(0, 150)), 16'($urandom_range(0, 4)));
            add_random(35, 6);
        end

        configure(1'b1, 16'd0, 16'd0, 16'hFFFF, 16'd0);
        add_random(20, 4);

        wait_idle();
        repeat (400) @(posedge clk);
        $display("covered %0d requests, %0d results, %0d packets released",
                 n_requests, n_results, n_released);
        $display("ten register settings incl. shared pool, disabled block, overflow, stall");
        if (errors == 0)
            $display("[acl_credit_flow_control_core] OK");
        else
            $display("[acl_credit_flow_control_core] ERROR");
        $finish;
    end
endmodule
`default_nettype wire

FILE: files.f
+incdir+design
design/acf_pkg.sv
design/acf_search.sv
design/acl_credit_flow_control_core.sv
bench/tb_acl_credit_flow_control_core.sv
